// ----- rtl/core/prb_pkg.sv -----
// Shared types and constants for the packet reorder buffer.
// No dependencies; prb_cmp and the top module import this package, prb_mem does not.
package prb_pkg;

    localparam int ID_W        = 32;
    localparam int HANDLE_W    = 16;
    localparam int CTX_W       = 2;
    localparam int MAX_RESULTS = 16;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic OP_ISSUE  = 1'b0;
    localparam logic OP_RETURN = 1'b1;

    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_DROPPED  = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_REORDER_ENABLE = 1'b0;

    typedef struct packed {
        logic                opcode;
        logic [CTX_W-1:0]    context_sel;
        logic [ID_W-1:0]     packet_id;
        logic [HANDLE_W-1:0] desc_handle;
    } item_word_t;

    typedef struct packed {
        logic [CTX_W-1:0]    out_context;
        logic [ID_W-1:0]     out_id;
        logic [HANDLE_W-1:0] out_handle;
        logic                status;
        logic                last;
    } result_word_t;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

// ----- rtl/core/prb_cmp.sv -----
// Shared id comparator used by the min search and the match check.
// Depends on prb_pkg.
module prb_cmp (
    input  logic [prb_pkg::ID_W-1:0] a,
    input  logic [prb_pkg::ID_W-1:0] b,
    output prb_pkg::cmp_res_t        res
);
    import prb_pkg::*;

    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule

// ----- rtl/core/prb_mem.sv -----
// Simple dual-port table memory: one write port, one registered read port.
// No package dependency.
module prb_mem #(
    parameter int DEPTH = 64,
    parameter int W     = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/packet_reorder_buffer_top.sv -----
// Packet reorder buffer: per-context issued/returned tables, in-order release.
// Issue: free-slot scan, drop word if full. A return while disabled is output as released.
// Return: free-slot scan of the returned table (a drop word if full), then for each released
// word a min search of both tables and a match check, and a closing search, on the shared
// comparator; output stalls hold it and the block is not ready meanwhile.
// Reset clears all valid bits at once; reorder_enable resets to 1. Needs prb_pkg/cmp/mem.
module packet_reorder_buffer_top #(
    parameter int CONTEXTS = 4,
    parameter int ENTRIES  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  prb_pkg::item_word_t            item,
    output logic                           result_valid,
    input  logic                           result_stall,
    output prb_pkg::result_word_t          result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [prb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [prb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [prb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import prb_pkg::*;

    localparam int NE = CONTEXTS * ENTRIES;
    localparam int AW = $clog2(NE);
    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);
    localparam logic [CW-1:0] LAST_SLOT = CW'(ENTRIES - 1);
    localparam logic [NRES_W-1:0] MAX_RES_C = NRES_W'(MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCAN_R,
        ST_SCAN_Q,
        ST_MATCH,
        ST_FLUSH
    } state_t;

    state_t                state_reg, state_next;
    logic                  enable_reg, enable_next;
    logic                  is_ret_reg, is_ret_next;
    logic [CTX_W-1:0]      ctx_reg, ctx_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  samp_vld_reg, samp_vld_next;
    logic [SW-1:0]         rd_slot_reg, rd_slot_next;
    logic                  found_r_reg, found_r_next;
    logic                  found_q_reg, found_q_next;
    logic [SW-1:0]         best_r_slot_reg, best_r_slot_next;
    logic [SW-1:0]         best_q_slot_reg, best_q_slot_next;
    logic [ID_W-1:0]       best_r_id_reg, best_r_id_next;
    logic [HANDLE_W-1:0]   best_r_handle_reg, best_r_handle_next;
    logic [ID_W-1:0]       best_q_id_reg, best_q_id_next;
    logic [NRES_W-1:0]     nres_reg, nres_next;
    logic                  pend_vld_reg, pend_vld_next;
    result_word_t          pend_reg, pend_next;
    logic                  out_vld_reg, out_vld_next;
    result_word_t          out_reg, out_next;
    logic [NE-1:0]         iss_vld_reg, iss_vld_next;
    logic [NE-1:0]         ret_vld_reg, ret_vld_next;

    logic                  iss_we;
    logic                  ret_we;
    logic [AW-1:0]         waddr;
    logic [AW-1:0]         raddr;
    logic [ID_W-1:0]       iss_rdata;
    logic [ID_W+HANDLE_W-1:0] ret_rdata;
    logic [ID_W-1:0]       cmp_a;
    logic [ID_W-1:0]       cmp_b;
    cmp_res_t              cmp_res;
    logic                  out_free;
    logic                  scan_issue;
    logic                  vbit;
    logic                  cfg_wr;

    prb_mem #(
        .DEPTH (NE),
        .W     (ID_W)
    ) u_iss_mem (
        .clk   (clk),
        .we    (iss_we),
        .waddr (waddr),
        .wdata (id_reg),
        .raddr (raddr),
        .rdata (iss_rdata)
    );

    prb_mem #(
        .DEPTH (NE),
        .W     (ID_W + HANDLE_W)
    ) u_ret_mem (
        .clk   (clk),
        .we    (ret_we),
        .waddr (waddr),
        .wdata ({id_reg, handle_reg}),
        .raddr (raddr),
        .rdata (ret_rdata)
    );

    prb_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign cfg_wr       = psel && penable && pwrite;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == REG_REORDER_ENABLE) ?
                          {{(CFG_DATA_W-1){1'b0}}, enable_reg} : '0;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_vld_reg;
    assign result       = out_reg;
    assign out_free     = !out_vld_reg || !result_stall;
    assign scan_issue   = (cnt_reg < ENTRIES_C);
    assign raddr        = base_reg + AW'(cnt_reg[SW-1:0]);

    always_comb
    begin
        if (state_reg == ST_MATCH)
        begin
            cmp_a = best_r_id_reg;
            cmp_b = best_q_id_reg;
        end
        else if (state_reg == ST_SCAN_R)
        begin
            cmp_a = ret_rdata[ID_W+HANDLE_W-1:HANDLE_W];
            cmp_b = best_r_id_reg;
        end
        else
        begin
            cmp_a = iss_rdata;
            cmp_b = best_q_id_reg;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        enable_next        = enable_reg;
        is_ret_next        = is_ret_reg;
        ctx_next           = ctx_reg;
        id_next            = id_reg;
        handle_next        = handle_reg;
        base_next          = base_reg;
        cnt_next           = cnt_reg;
        rd_vld_next        = 1'b0;
        samp_vld_next      = samp_vld_reg;
        rd_slot_next       = rd_slot_reg;
        found_r_next       = found_r_reg;
        found_q_next       = found_q_reg;
        best_r_slot_next   = best_r_slot_reg;
        best_q_slot_next   = best_q_slot_reg;
        best_r_id_next     = best_r_id_reg;
        best_r_handle_next = best_r_handle_reg;
        best_q_id_next     = best_q_id_reg;
        nres_next          = nres_reg;
        pend_vld_next      = pend_vld_reg;
        pend_next          = pend_reg;
        out_vld_next       = out_vld_reg && result_stall;
        out_next           = out_reg;
        iss_vld_next       = iss_vld_reg;
        ret_vld_next       = ret_vld_reg;
        iss_we             = 1'b0;
        ret_we             = 1'b0;
        waddr              = raddr;
        vbit               = 1'b0;

        if (cfg_wr && (paddr[2] == REG_REORDER_ENABLE))
        begin
            enable_next = pwdata[0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    is_ret_next = (item.opcode == OP_RETURN);
                    ctx_next    = item.context_sel;
                    id_next     = item.packet_id;
                    handle_next = item.desc_handle;
                    base_next   = AW'(int'(item.context_sel) * ENTRIES);
                    cnt_next    = '0;
                    nres_next   = '0;
                    if (int'(item.context_sel) < CONTEXTS)
                    begin
                        if (enable_reg)
                        begin
                            state_next = ST_FREE;
                        end
                        else if (item.opcode == OP_RETURN)
                        begin
                            pend_next.out_context = item.context_sel;
                            pend_next.out_id      = item.packet_id;
                            pend_next.out_handle  = item.desc_handle;
                            pend_next.status      = STATUS_RELEASED;
                            pend_next.last        = 1'b0;
                            pend_vld_next         = 1'b1;
                            state_next            = ST_FLUSH;
                        end
                    end
                end
            end

            ST_FREE:
            begin
                vbit = is_ret_reg ? ret_vld_reg[raddr] : iss_vld_reg[raddr];
                if (!vbit)
                begin
                    if (is_ret_reg)
                    begin
                        ret_we              = 1'b1;
                        ret_vld_next[raddr] = 1'b1;
                    end
                    else
                    begin
                        iss_we              = 1'b1;
                        iss_vld_next[raddr] = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    pend_next.out_context = ctx_reg;
                    pend_next.out_id      = id_reg;
                    pend_next.out_handle  = is_ret_reg ? handle_reg : '0;
                    pend_next.status      = STATUS_DROPPED;
                    pend_next.last        = 1'b0;
                    pend_vld_next         = 1'b1;
                    nres_next             = NRES_W'(1);
                    if (!is_ret_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (is_ret_reg && (!vbit || (cnt_reg == LAST_SLOT)))
                begin
                    cnt_next     = '0;
                    found_r_next = 1'b0;
                    state_next   = (nres_next == MAX_RES_C) ? ST_FLUSH : ST_SCAN_R;
                end
            end

            ST_SCAN_R, ST_SCAN_Q:
            begin
                vbit = (state_reg == ST_SCAN_R) ? ret_vld_reg[raddr] : iss_vld_reg[raddr];
                if (scan_issue)
                begin
                    rd_vld_next   = 1'b1;
                    samp_vld_next = vbit;
                    rd_slot_next  = cnt_reg[SW-1:0];
                    cnt_next      = cnt_reg + CW'(1);
                end
                if (rd_vld_reg && samp_vld_reg)
                begin
                    if (state_reg == ST_SCAN_R)
                    begin
                        if (!found_r_reg || cmp_res.lt)
                        begin
                            found_r_next       = 1'b1;
                            best_r_slot_next   = rd_slot_reg;
                            best_r_id_next     = ret_rdata[ID_W+HANDLE_W-1:HANDLE_W];
                            best_r_handle_next = ret_rdata[HANDLE_W-1:0];
                        end
                    end
                    else if (!found_q_reg || cmp_res.lt)
                    begin
                        found_q_next     = 1'b1;
                        best_q_slot_next = rd_slot_reg;
                        best_q_id_next   = iss_rdata;
                    end
                end
                if (!scan_issue && !rd_vld_reg)
                begin
                    if (state_reg == ST_SCAN_R)
                    begin
                        cnt_next     = '0;
                        found_q_next = 1'b0;
                        state_next   = found_r_reg ? ST_SCAN_Q : ST_FLUSH;
                    end
                    else
                    begin
                        state_next = found_q_reg ? ST_MATCH : ST_FLUSH;
                    end
                end
            end

            ST_MATCH:
            begin
                if (!cmp_res.eq)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!pend_vld_reg || out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_next      = pend_reg;
                        out_next.last = 1'b0;
                    end
                    pend_next.out_context = ctx_reg;
                    pend_next.out_id      = best_r_id_reg;
                    pend_next.out_handle  = best_r_handle_reg;
                    pend_next.status      = STATUS_RELEASED;
                    pend_next.last        = 1'b0;
                    pend_vld_next         = 1'b1;
                    nres_next             = nres_reg + NRES_W'(1);
                    ret_vld_next[base_reg + AW'(best_r_slot_reg)] = 1'b0;
                    iss_vld_next[base_reg + AW'(best_q_slot_reg)] = 1'b0;
                    cnt_next              = '0;
                    found_r_next          = 1'b0;
                    state_next = (nres_next == MAX_RES_C) ? ST_FLUSH : ST_SCAN_R;
                end
            end

            ST_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            enable_reg   <= 1'b1;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            found_r_reg  <= 1'b0;
            found_q_reg  <= 1'b0;
            nres_reg     <= '0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_reg      <= '0;
            iss_vld_reg  <= '0;
            ret_vld_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            enable_reg   <= enable_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= rd_vld_next;
            found_r_reg  <= found_r_next;
            found_q_reg  <= found_q_next;
            nres_reg     <= nres_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
            out_reg      <= out_next;
            iss_vld_reg  <= iss_vld_next;
            ret_vld_reg  <= ret_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_ret_reg        <= is_ret_next;
        ctx_reg           <= ctx_next;
        id_reg            <= id_next;
        handle_reg        <= handle_next;
        base_reg          <= base_next;
        samp_vld_reg      <= samp_vld_next;
        rd_slot_reg       <= rd_slot_next;
        best_r_slot_reg   <= best_r_slot_next;
        best_q_slot_reg   <= best_q_slot_next;
        best_r_id_reg     <= best_r_id_next;
        best_r_handle_reg <= best_r_handle_next;
        best_q_id_reg     <= best_q_id_next;
        pend_reg          <= pend_next;
    end

`ifndef ASSERT_OFF
    a_idle_no_pending: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_vld_reg
    ) else $error("pending word left behind at idle");

    a_result_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        nres_reg <= MAX_RES_C
    ) else $error("result count beyond limit");

    a_scan_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        cnt_reg <= ENTRIES_C
    ) else $error("scan counter beyond table");

    a_flush_marks_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && pend_vld_reg && out_free)
            |=> (result_valid && result.last && state_reg == ST_IDLE)
    ) else $error("final word not marked last");
`endif

endmodule
